/* src/enc_dfr_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Encoder SPI response deframer package
// Frame kinds, frame lengths, the CRC-8 byte step and the result record
// shared by the deframer core and the top level.
// ----------------------------------------------------------------------------
package enc_dfr_pkg;

    localparam int unsigned ByteW   = 8;
    localparam int unsigned KindW   = 3;
    localparam int unsigned IndexW  = 4;
    localparam int unsigned PosW    = 14;
    localparam int unsigned ReadW   = 16;
    localparam int unsigned StatusW = 5;
    localparam int unsigned SerialW = 48;

    localparam logic [ByteW-1:0] CrcPoly = 8'h97;

    typedef enum logic [KindW-1:0] {
        KIND_GENERAL = 3'd0,
        KIND_SERIAL  = 3'd1,
        KIND_SPEED   = 3'd2,
        KIND_TEMP    = 3'd3,
        KIND_STATUS  = 3'd4
    } kind_t;

    typedef struct packed {
        kind_t                     frame_op;
        logic [PosW-1:0]           position_raw;
        logic                      error_flag;
        logic                      warning_flag;
        logic                      crc_ok;
        logic signed [ReadW-1:0]   signed_reading;
        logic [StatusW-1:0]        status_flags;
        logic [SerialW-1:0]        serial_number;
    } result_t;

    // Unknown kinds are treated as general frames.
    function automatic kind_t kind_from_op(input logic [KindW-1:0] op);
        kind_t k;
        case (op)
            KIND_SERIAL: k = KIND_SERIAL;
            KIND_SPEED:  k = KIND_SPEED;
            KIND_TEMP:   k = KIND_TEMP;
            KIND_STATUS: k = KIND_STATUS;
            default:     k = KIND_GENERAL;
        endcase
        return k;
    endfunction

    // Index of the CRC byte, which is the last byte of the frame.
    function automatic logic [IndexW-1:0] last_index(input kind_t kind);
        logic [IndexW-1:0] idx;
        case (kind)
            KIND_SERIAL: idx = 4'd8;
            KIND_SPEED:  idx = 4'd4;
            KIND_TEMP:   idx = 4'd4;
            KIND_STATUS: idx = 4'd3;
            default:     idx = 4'd2;
        endcase
        return idx;
    endfunction

    // Eight shifts of the MSB-first CRC register with no data folded in.
    function automatic logic [ByteW-1:0] crc_table(input logic [ByteW-1:0] v);
        logic [ByteW-1:0] c;
        c = v;
        for (int k = 0; k < 8; k++) begin
            if (c[ByteW-1]) begin
                c = {c[ByteW-2:0], 1'b0} ^ CrcPoly;
            end else begin
                c = {c[ByteW-2:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage
`default_nettype wire

/* src/enc_dfr_core.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Encoder SPI response deframer core
// Holds the frame state (byte count, kind, running CRC, head and payload
// bytes), advances it by one byte per step and decodes the result on the
// last byte of a frame.
// ----------------------------------------------------------------------------
module enc_dfr_core (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           step,
    input  wire logic [enc_dfr_pkg::ByteW-1:0]  rx_byte,
    input  wire logic [enc_dfr_pkg::KindW-1:0]  op,
    output logic                                at_last,
    output enc_dfr_pkg::result_t                result
);

    logic [enc_dfr_pkg::IndexW-1:0]  byte_index_reg, byte_index_next;
    enc_dfr_pkg::kind_t              frame_kind_reg, frame_kind_next;
    logic [enc_dfr_pkg::ByteW-1:0]   crc_reg, crc_next;
    logic [2*enc_dfr_pkg::ByteW-1:0] head_reg, head_next;
    logic [enc_dfr_pkg::SerialW-1:0] payload_reg, payload_next;

    logic                            is_first;
    logic [enc_dfr_pkg::ByteW-1:0]   crc_shifted;
    logic [enc_dfr_pkg::ByteW-1:0]   b1;

    assign is_first    = (byte_index_reg == '0);
    assign at_last     = !is_first &&
                         !(byte_index_reg < enc_dfr_pkg::last_index(frame_kind_reg));
    assign crc_shifted = enc_dfr_pkg::crc_table(crc_reg);
    assign b1          = head_reg[enc_dfr_pkg::ByteW-1:0];

    always_comb begin
        byte_index_next = byte_index_reg;
        frame_kind_next = frame_kind_reg;
        crc_next        = crc_reg;
        head_next       = head_reg;
        payload_next    = payload_reg;
        if (step) begin
            if (is_first) begin
                frame_kind_next = enc_dfr_pkg::kind_from_op(op);
                crc_next        = rx_byte;
                head_next       = {rx_byte, 8'h00};
                byte_index_next = 4'd1;
            end else if (!at_last) begin
                crc_next = rx_byte ^ crc_shifted;
                if (byte_index_reg == 4'd1) begin
                    head_next = {head_reg[2*enc_dfr_pkg::ByteW-1:enc_dfr_pkg::ByteW],
                                 rx_byte};
                end else begin
                    payload_next = {payload_reg[enc_dfr_pkg::SerialW-enc_dfr_pkg::ByteW-1:0],
                                    rx_byte};
                end
                byte_index_next = byte_index_reg + 4'd1;
            end else begin
                byte_index_next = '0;
            end
        end
    end

    // The result is read while the CRC byte is on the input.
    always_comb begin
        result                = '0;
        result.frame_op       = frame_kind_reg;
        result.position_raw   = {head_reg[2*enc_dfr_pkg::ByteW-1:enc_dfr_pkg::ByteW],
                                 b1[7:2]};
        result.error_flag     = !b1[1];
        result.warning_flag   = !b1[0];
        result.crc_ok         = (crc_shifted == ~rx_byte);
        case (frame_kind_reg)
            enc_dfr_pkg::KIND_SPEED,
            enc_dfr_pkg::KIND_TEMP: begin
                result.signed_reading = payload_reg[enc_dfr_pkg::ReadW-1:0];
            end
            enc_dfr_pkg::KIND_STATUS: begin
                result.status_flags = payload_reg[7:3];
            end
            enc_dfr_pkg::KIND_SERIAL: begin
                result.serial_number = payload_reg;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            byte_index_reg <= '0;
            frame_kind_reg <= enc_dfr_pkg::KIND_GENERAL;
            crc_reg        <= '0;
            head_reg       <= '0;
        end else begin
            byte_index_reg <= byte_index_next;
            frame_kind_reg <= frame_kind_next;
            crc_reg        <= crc_next;
            head_reg       <= head_next;
        end
    end

    always_ff @(posedge aclk) begin
        payload_reg <= payload_next;
    end

endmodule
`default_nettype wire

/* src/encoder_spi_response_deframer.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Encoder SPI response deframer
// Registered byte stream in, one decoded result per response frame out.
// ----------------------------------------------------------------------------
// Bytes of an absolute encoder response enter one per transfer, with the
// frame kind on tuser sampled on the first byte of each frame (general 3,
// serial 9, speed 5, temperature 5, status 4 bytes; unknown kinds count as
// general). The block takes one byte every cycle: a byte is registered on
// acceptance, then advances the frame state and CRC-8, and the result of a
// frame is registered on the master side when its last byte leaves the
// input register. Throughput drops only while a finished result is held
// waiting on m_tready and the next frame's last byte reaches the core.
// ----------------------------------------------------------------------------
module encoder_spi_response_deframer (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] rx_byte
    input  wire logic [2:0]  s_tuser,   // [2:0] op
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [87:0]      m_tdata,   // [13:0] position_raw, [14] error_flag,
                                        // [15] warning_flag, [16] crc_ok,
                                        // [32:17] signed_reading, [37:33] status_flags,
                                        // [85:38] serial_number, [87:86] zero
    output logic [2:0]       m_tuser    // [2:0] frame_op
);

    logic                              in_valid_reg, in_valid_next;
    logic [enc_dfr_pkg::ByteW-1:0]     in_byte_reg;
    logic [enc_dfr_pkg::KindW-1:0]     in_op_reg;
    logic                              m_valid_reg, m_valid_next;
    enc_dfr_pkg::result_t              m_result_reg;

    logic                              at_last;
    logic                              out_free;
    logic                              advance;
    logic                              s_fire;
    enc_dfr_pkg::result_t              core_result;

    enc_dfr_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (advance),
        .rx_byte (in_byte_reg),
        .op      (in_op_reg),
        .at_last (at_last),
        .result  (core_result)
    );

    // A registered byte moves on unless it completes a frame and the result
    // register is still occupied.
    assign out_free = !m_valid_reg || m_tready;
    assign advance  = in_valid_reg && (!at_last || out_free);
    assign s_tready = !in_valid_reg || advance;
    assign s_fire   = s_tvalid && s_tready;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_fire) begin
            in_valid_next = 1'b1;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end
        m_valid_next = m_valid_reg;
        if (advance && at_last) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            in_byte_reg <= s_tdata;
            in_op_reg   <= s_tuser;
        end
        if (advance && at_last) begin
            m_result_reg <= core_result;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_result_reg.frame_op;
    assign m_tdata  = {2'b00,
                       m_result_reg.serial_number,
                       m_result_reg.status_flags,
                       m_result_reg.signed_reading,
                       m_result_reg.crc_ok,
                       m_result_reg.warning_flag,
                       m_result_reg.error_flag,
                       m_result_reg.position_raw};

endmodule
`default_nettype wire
